[src/itrs_pkg.sv]
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared widths, codes, command/status types and the digit symbol function
// for the integer to radix string converter.
// ----------------------------------------------------------------------------
package itrs_pkg;

    localparam int unsigned NUM_W      = 64;
    localparam int unsigned RADIX_W    = 6;
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned ERR_W      = 2;
    localparam int unsigned DIGIT_W    = 6;

    localparam int unsigned MAX_DIGITS_DEFAULT = 64;

    localparam int unsigned RADIX_MIN  = 2;
    localparam int unsigned RADIX_MAX  = 36;

    // restoring division, several quotient bits per cycle
    localparam int unsigned BITS_PER_CYCLE = 4;
    localparam int unsigned DIV_CYCLES     = NUM_W / BITS_PER_CYCLE;
    localparam int unsigned STEP_W         = $clog2(DIV_CYCLES);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_NEGATIVE = 2'd1,
        ERR_RADIX    = 2'd2,
        ERR_LENGTH   = 2'd3
    } itrs_err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV,
        ST_WRITE,
        ST_PREP,
        ST_EMIT,
        ST_LOAD
    } itrs_state_t;

    typedef struct packed {
        logic load_in;
        logic load_err;
        logic div_init;
        logic div_step;
        logic wr_digit;
        logic prep;
        logic load_pad;
        logic rd_digit;
        logic load_digit;
    } itrs_cmd_t;

    typedef struct packed {
        itrs_err_t in_err;
        logic      step_done;
        logic      quot_zero;
        logic      count_full;
        logic      pad_zero;
        logic      last_digit;
        logic      out_free;
    } itrs_status_t;

    // digit value to ASCII, values above 35 clamp to 'Z'
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] c;
        begin
            c = (d > DIGIT_W'(RADIX_MAX - 1)) ? DIGIT_W'(RADIX_MAX - 1) : d;
            if (c < DIGIT_W'(10))
                return CHAR_ZERO + CHAR_W'(c);
            else
                return CHAR_A + CHAR_W'(c) - CHAR_W'(10);
        end
    endfunction

endpackage

[src/itrs_in_if.sv]
// ----------------------------------------------------------------------------
// itrs_in_if
// Valid/ready channel carrying one conversion request.
// ----------------------------------------------------------------------------
interface itrs_in_if;
    import itrs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [NUM_W-1:0]    number;
    logic        [RADIX_W-1:0]  radix;
    logic        [LEN_W-1:0]    min_width;

    modport source (output valid, number, radix, min_width, input ready);
    modport sink   (input valid, number, radix, min_width, output ready);
endinterface

[src/itrs_out_if.sv]
// ----------------------------------------------------------------------------
// itrs_out_if
// Valid/ready channel carrying one output character.
// ----------------------------------------------------------------------------
interface itrs_out_if;
    import itrs_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  digit_char;
    logic               last_char;
    logic [ERR_W-1:0]   error_code;

    modport source (output valid, digit_char, last_char, error_code, input ready);
    modport sink   (input valid, digit_char, last_char, error_code, output ready);
endinterface

[src/integer_to_radix_string.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_string
// Converts a non-negative 64-bit integer to ASCII digits in radix 2..36,
// zero padded to a minimum length, one character per output transaction,
// most significant first, the final character marked.
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                  transaction
//  --------  ----  ---------------------------------------  ----------------
//  in_ch     in    number[63:0] radix[5:0] min_width[6:0]   one request
//  out_ch    out   digit_char[7:0] last_char error_code[1:0] one character
//
//  Sequence: a rejected request goes straight to one error character; otherwise
//  each digit takes divider steps covering all 64 quotient bits, 4 at a time,
//  and one store write, then a setup step, one load per pad and a read and a load per digit.
//  Reset clears the controller and output valid; every digit is written
//  before it is read, so the digit store needs none.
//  Output stalls hold the result register and pause emission; input waits.
//
module integer_to_radix_string #(
    parameter int unsigned MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    itrs_in_if.sink    in_ch,
    itrs_out_if.source out_ch
);
    import itrs_pkg::*;

    itrs_cmd_t    cmd;
    itrs_status_t status;

    // Controller: owns the input handshake and sequences the datapath
    itrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: divider, digit store and output register
    itrs_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .number     (in_ch.number),
        .radix      (in_ch.radix),
        .min_width  (in_ch.min_width),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .digit_char (out_ch.digit_char),
        .last_char  (out_ch.last_char),
        .error_code (out_ch.error_code)
    );

endmodule

[src/itrs_ram.sv]
// ----------------------------------------------------------------------------
// itrs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module itrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/itrs_dp.sv]
// ----------------------------------------------------------------------------
// itrs_dp
// Datapath: operand registers, iterative divider, digit store, pad and
// digit counters, and the output register.
// ----------------------------------------------------------------------------
module itrs_dp #(
    parameter int unsigned MAX_DIGITS = itrs_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  itrs_pkg::itrs_cmd_t               cmd,
    output itrs_pkg::itrs_status_t            status,
    input  logic signed [itrs_pkg::NUM_W-1:0]   number,
    input  logic        [itrs_pkg::RADIX_W-1:0] radix,
    input  logic        [itrs_pkg::LEN_W-1:0]   min_width,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic        [itrs_pkg::CHAR_W-1:0]  digit_char,
    output logic                              last_char,
    output logic        [itrs_pkg::ERR_W-1:0]   error_code
);
    import itrs_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_DIGITS);

    logic [NUM_W-1:0]   quot_reg,  quot_next;
    logic [DIGIT_W-1:0] rem_reg,   rem_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [LEN_W-1:0]   min_len_reg;
    itrs_err_t          err_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   pad_reg;
    logic [CNT_W-1:0]   idx_reg;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic [ERR_W-1:0]   code_reg;

    itrs_err_t          in_err;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   min_ext;
    logic [DIGIT_W-1:0] ram_rd_data;
    logic [CNT_W-1:0]   rd_index;

    // request checks, in priority order
    always_comb
    begin
        priority if (number[NUM_W-1])
            in_err = ERR_NEGATIVE;
        else if (radix < RADIX_W'(RADIX_MIN) || radix > RADIX_W'(RADIX_MAX))
            in_err = ERR_RADIX;
        else if (32'(min_width) > MAX_DIGITS)
            in_err = ERR_LENGTH;
        else
            in_err = ERR_NONE;
    end

    // restoring division, BITS_PER_CYCLE quotient bits a cycle
    always_comb
    begin
        logic [DIGIT_W:0] trial;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            trial     = {rem_next, quot_next[NUM_W-1]};
            quot_next = {quot_next[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg})
            begin
                trial        = trial - {1'b0, radix_reg};
                quot_next[0] = 1'b1;
            end
            rem_next = trial[DIGIT_W-1:0];
        end
    end

    assign min_ext  = CNT_W'(min_len_reg);
    assign total    = (min_ext > count_reg) ? min_ext : count_reg;
    assign rd_index = idx_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            quot_reg    <= {1'b0, number[NUM_W-2:0]};
            rem_reg     <= '0;
            step_reg    <= '0;
            radix_reg   <= radix;
            min_len_reg <= min_width;
            err_reg     <= in_err;
            count_reg   <= '0;
        end
        else
        begin
            if (cmd.div_step)
            begin
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.div_init)
            begin
                rem_reg  <= '0;
                step_reg <= '0;
            end
            if (cmd.wr_digit)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end

        if (cmd.prep)
        begin
            pad_reg <= total - count_reg;
            idx_reg <= count_reg;
        end
        else if (cmd.load_pad)
        begin
            pad_reg <= pad_reg - CNT_W'(1);
        end
        else if (cmd.load_digit)
        begin
            idx_reg <= idx_reg - CNT_W'(1);
        end
    end

    itrs_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_store (
        .clk     (clk),
        .wr_en   (cmd.wr_digit),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (rem_reg),
        .rd_en   (cmd.rd_digit),
        .rd_addr (rd_index[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_err || cmd.load_pad || cmd.load_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            char_reg <= CHAR_NONE;
            last_reg <= 1'b1;
            code_reg <= err_reg;
        end
        else if (cmd.load_pad)
        begin
            char_reg <= CHAR_ZERO;
            last_reg <= (pad_reg == CNT_W'(1)) && (idx_reg == '0);
            code_reg <= ERR_NONE;
        end
        else if (cmd.load_digit)
        begin
            char_reg <= digit_to_char(ram_rd_data);
            last_reg <= (idx_reg == CNT_W'(1));
            code_reg <= ERR_NONE;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_char  = last_reg;
    assign error_code = code_reg;

    assign status.in_err     = in_err;
    assign status.step_done  = (step_reg == STEP_W'(DIV_CYCLES - 1));
    assign status.quot_zero  = (quot_reg == '0);
    assign status.count_full = (count_reg == CNT_W'(MAX_DIGITS - 1));
    assign status.pad_zero   = (pad_reg == '0);
    assign status.last_digit = (idx_reg == CNT_W'(1));
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

[src/itrs_ctrl.sv]
// ----------------------------------------------------------------------------
// itrs_ctrl
// Controller: sequences request capture, division, padding and emission.
// ----------------------------------------------------------------------------
module itrs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  itrs_pkg::itrs_status_t status,
    output itrs_pkg::itrs_cmd_t    cmd
);
    import itrs_pkg::*;

    itrs_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (status.in_err != ERR_NONE) ? ST_ERR : ST_DIV;
                end
            end
            ST_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.load_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.step_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_digit = 1'b1;
                if (status.quot_zero || status.count_full)
                begin
                    state_next = ST_PREP;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.pad_zero)
                begin
                    cmd.load_pad = status.out_free;
                end
                else
                begin
                    cmd.rd_digit = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    state_next     = status.last_digit ? ST_IDLE : ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
